>>> sv/cau_pkg.sv
package cau_pkg;

	localparam int DATA_W = 16;
	localparam int FRAC_W = 8;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_MOD = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t                  opcode;
		logic signed [DATA_W-1:0] a_re;
		logic signed [DATA_W-1:0] a_im;
		logic signed [DATA_W-1:0] b_re;
		logic signed [DATA_W-1:0] b_im;
	} op_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] res_re;
		logic signed [DATA_W-1:0] res_im;
		logic                     saturated;
	} res_item_t;

endpackage

>>> sv/complex_arith_unit.sv
// Channel  | Valid     | Stall     | Payload  | Type
// request  | op_valid  | op_stall  | op_data  | op_item_t  (opcode, a_re, a_im, b_re, b_im)
// result   | res_valid | res_stall | res_data | res_item_t (res_re, res_im, saturated)
//
// One transaction per cycle enters while op_stall is low; every opcode takes the same path.
// The latency is set by the square root, which resolves one root bit per stage.
// Reset clears only the stage valid bits; no clearing pass.
// A stalled result holds the last stage; earlier stages keep moving into empty
// slots, so op_stall rises only when every stage holds a transaction.
module complex_arith_unit
	import cau_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      op_valid,
	output logic      op_stall,
	input  op_item_t  op_data,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res_data
);

	localparam int DW = DATA_W;
	localparam int FW = FRAC_W;
	localparam int PW = 2 * DW;
	localparam int WW = 2 * DW + 1;
	localparam int NR = DW;
	localparam int L  = NR + 4;
	localparam logic [WW-1:0] RND = WW'((64'd1 << FW) - 64'd1);

	typedef struct packed {
		logic          is_mod;
		logic [DW-1:0] re;
		logic [DW-1:0] im;
		logic          flag;
	} side_t;

	logic [L:1] vld_sn;
	logic [L:1] vld_prev;
	logic [L:1] adv;

	logic signed [DW-1:0] ar, ai, br, bi, mb_re, mb_im;

	opcode_t              op_s1;
	logic signed [DW:0]   sum_re_s1, sum_im_s1;
	logic signed [PW-1:0] prr_s1, pii_s1, pri_s1, pir_s1;

	opcode_t              op_s2;
	logic signed [DW:0]   sum_re_s2, sum_im_s2;
	logic signed [WW-1:0] wre_s2, wim_s2;

	logic signed [WW-1:0] t_re, t_im, v_re, v_im;
	logic [DW:0]          sat_re, sat_im;

	logic                 is_mod_s3;
	logic [DW-1:0]        re_s3, im_s3;
	logic                 flag_s3;
	logic [PW-1:0]        rad_s3;

	side_t                side_sn [NR];
	logic [DW-1:0]        root;
	res_item_t            out_sn;

	function automatic logic [DW:0] sat_fn(input logic [WW-1:0] v);
		logic        pos_ovf;
		logic        neg_ovf;
		logic [DW:0] r;
		pos_ovf = !v[WW-1] && (|v[WW-2:DW-1]);
		neg_ovf = v[WW-1] && !(&v[WW-2:DW-1]);
		if (pos_ovf) begin
			r = {1'b1, 1'b0, {(DW-1){1'b1}}};
		end else if (neg_ovf) begin
			r = {1'b1, 1'b1, {(DW-1){1'b0}}};
		end else begin
			r = {1'b0, v[DW-1:0]};
		end
		return r;
	endfunction

	// A stage advances when it is empty or the stage after it advances.
	always_comb begin
		adv[L] = !vld_sn[L] || !res_stall;
		for (int k = L - 1; k >= 1; k--) begin
			adv[k] = !vld_sn[k] || adv[k+1];
		end
	end

	assign vld_prev = {vld_sn[L-1:1], op_valid};
	assign op_stall = !adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= '0;
		end else begin
			for (int k = 1; k <= L; k++) begin
				if (adv[k]) begin
					vld_sn[k] <= vld_prev[k];
				end
			end
		end
	end

	// Stage 1: sums and the four products; modulus squares A through the same multipliers.
	assign ar    = op_data.a_re;
	assign ai    = op_data.a_im;
	assign br    = op_data.b_re;
	assign bi    = op_data.b_im;
	assign mb_re = (op_data.opcode == OP_MOD) ? ar : br;
	assign mb_im = (op_data.opcode == OP_MOD) ? ai : bi;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			op_s1 <= op_data.opcode;
			if (op_data.opcode == OP_SUB) begin
				sum_re_s1 <= {ar[DW-1], ar} - {br[DW-1], br};
				sum_im_s1 <= {ai[DW-1], ai} - {bi[DW-1], bi};
			end else begin
				sum_re_s1 <= {ar[DW-1], ar} + {br[DW-1], br};
				sum_im_s1 <= {ai[DW-1], ai} + {bi[DW-1], bi};
			end
			prr_s1 <= ar * mb_re;
			pii_s1 <= ai * mb_im;
			pri_s1 <= ar * bi;
			pir_s1 <= ai * br;
		end
	end

	// Stage 2: combine products at full width.
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			op_s2     <= op_s1;
			sum_re_s2 <= sum_re_s1;
			sum_im_s2 <= sum_im_s1;
			if (op_s1 == OP_MOD) begin
				wre_s2 <= {prr_s1[PW-1], prr_s1} + {pii_s1[PW-1], pii_s1};
			end else begin
				wre_s2 <= {prr_s1[PW-1], prr_s1} - {pii_s1[PW-1], pii_s1};
			end
			wim_s2 <= {pri_s1[PW-1], pri_s1} + {pir_s1[PW-1], pir_s1};
		end
	end

	// Stage 3: truncate products toward zero, saturate, hand the radicand to the root.
	always_comb begin
		t_re = wre_s2 + (wre_s2[WW-1] ? RND : '0);
		t_im = wim_s2 + (wim_s2[WW-1] ? RND : '0);
		unique case (op_s2)
			OP_ADD, OP_SUB: begin
				v_re = {{(WW-DW-1){sum_re_s2[DW]}}, sum_re_s2};
				v_im = {{(WW-DW-1){sum_im_s2[DW]}}, sum_im_s2};
			end
			OP_MUL: begin
				v_re = t_re >>> FW;
				v_im = t_im >>> FW;
			end
			OP_MOD: begin
				v_re = '0;
				v_im = '0;
			end
			default: begin
				v_re = '0;
				v_im = '0;
			end
		endcase
		sat_re = sat_fn(v_re);
		sat_im = sat_fn(v_im);
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			is_mod_s3 <= (op_s2 == OP_MOD);
			re_s3     <= sat_re[DW-1:0];
			im_s3     <= sat_im[DW-1:0];
			flag_s3   <= sat_re[DW] || sat_im[DW];
			rad_s3    <= wre_s2[PW-1:0];
		end
	end

	cau_isqrt #(
		.ROOT_W (NR)
	) u_isqrt (
		.clk  (clk),
		.adv  (adv[NR+3:4]),
		.rad  (rad_s3),
		.root (root)
	);

	// Carry finished results alongside the root stages.
	for (genvar k = 0; k < NR; k++) begin : g_side
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (adv[4]) begin
					side_sn[0] <= '{is_mod: is_mod_s3, re: re_s3, im: im_s3, flag: flag_s3};
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv[k+4]) begin
					side_sn[k] <= side_sn[k-1];
				end
			end
		end
	end

	// Output stage: pick the root for modulus and clip it to the positive range.
	always_ff @(posedge clk) begin
		if (adv[L]) begin
			if (side_sn[NR-1].is_mod) begin
				out_sn.res_re    <= root[DW-1] ? {1'b0, {(DW-1){1'b1}}} : root;
				out_sn.res_im    <= '0;
				out_sn.saturated <= root[DW-1];
			end else begin
				out_sn.res_re    <= side_sn[NR-1].re;
				out_sn.res_im    <= side_sn[NR-1].im;
				out_sn.saturated <= side_sn[NR-1].flag;
			end
		end
	end

	assign res_valid = vld_sn[L];
	assign res_data  = out_sn;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		op_stall |-> (res_stall && (&vld_sn)))
		else $error("request stalled while the pipeline has room");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(op_valid && !op_stall) |=> vld_sn[1])
		else $error("accepted transaction missing from stage 1");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_sn[L-1] && !res_stall) |=> res_valid)
		else $error("transaction lost before the output stage");

	a_mod_result: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_sn[L-1] && adv[L] && side_sn[NR-1].is_mod)
		|=> (!res_data.res_re[DW-1] && (res_data.res_im == '0)))
		else $error("modulus result negative or with imaginary part");

endmodule

>>> sv/cau_isqrt.sv
module cau_isqrt #(
	parameter int ROOT_W = 16
) (
	input  logic                  clk,
	input  logic [ROOT_W-1:0]     adv,
	input  logic [2*ROOT_W-1:0]   rad,
	output logic [ROOT_W-1:0]     root
);

	localparam int XW  = 2 * ROOT_W;
	localparam int RMW = ROOT_W + 1;
	localparam int SW  = ROOT_W + 3;

	logic [XW-1:0]     x_sn [ROOT_W];
	logic [ROOT_W-1:0] q_sn [ROOT_W];
	logic [RMW-1:0]    r_sn [ROOT_W];

	// One root bit per stage, most significant bit first.
	for (genvar j = 0; j < ROOT_W; j++) begin : g_step
		logic [XW-1:0]     x_in;
		logic [ROOT_W-1:0] q_in;
		logic [RMW-1:0]    r_in;
		logic [SW-1:0]     r_sh;
		logic [SW-1:0]     trial;
		logic              take;

		if (j == 0) begin : g_first
			assign x_in = rad;
			assign q_in = '0;
			assign r_in = '0;
		end else begin : g_next
			assign x_in = x_sn[j-1];
			assign q_in = q_sn[j-1];
			assign r_in = r_sn[j-1];
		end

		// bring down the next two radicand bits and try root*4+1
		assign r_sh  = {r_in, x_in[XW-1 -: 2]};
		assign trial = {1'b0, q_in, 2'b01};
		assign take  = (r_sh >= trial);

		always_ff @(posedge clk) begin
			if (adv[j]) begin
				x_sn[j] <= {x_in[XW-3:0], 2'b00};
				q_sn[j] <= {q_in[ROOT_W-2:0], take};
				r_sn[j] <= take ? RMW'(r_sh - trial) : r_sh[RMW-1:0];
			end
		end
	end

	assign root = q_sn[ROOT_W-1];

endmodule

>>> sim/tb_top.sv
module tb_top;
	import cau_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 11;
	localparam int RANDOM_ITEMS = 1650;
	localparam int PIPE_DEPTH   = DATA_W + 4;
	localparam int CYCLE_LIMIT  = 400000;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef struct {
		op_item_t  item;
		bit        typed;
		res_item_t want;
	} stim_row_t;

	logic      clk;
	logic      arst_n;
	logic      op_valid;
	logic      op_stall;
	op_item_t  op_data;
	logic      res_valid;
	logic      res_stall;
	res_item_t res_data;

	res_item_t pending_results[$];
	stim_row_t dir_tab[$];
	int        mismatch_count = 0;
	int        result_index   = 0;
	int        cycle_count    = 0;
	int        burst_left     = 1;
	int        stall_left     = 0;
	int        stall_mode     = 0;
	op_item_t  rand_item;

	complex_arith_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_stall  (op_stall),
		.op_data   (op_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Clip to the signed word range and flag any clipping.
	function automatic word_t clip_word(input longint v, inout bit clipped);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (DATA_W - 1)) - 1;
		lo = -(longint'(1) <<< (DATA_W - 1));
		if (v > hi) begin
			clipped = 1'b1;
			return word_t'(hi);
		end
		if (v < lo) begin
			clipped = 1'b1;
			return word_t'(lo);
		end
		return word_t'(v);
	endfunction

	// Drop the extra fraction bits of a product sum, rounding toward zero.
	function automatic longint trunc_frac(input longint p);
		longint mag;
		mag = (p < 0) ? -p : p;
		mag = mag >>> FRAC_W;
		return (p < 0) ? -mag : mag;
	endfunction

	function automatic longint floor_sqrt(input longint x);
		longint r;
		longint t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (longint'(1) <<< b);
			if (t * t <= x)
				r = t;
		end
		return r;
	endfunction

	function automatic res_item_t complex_op_result(input op_item_t it);
		res_item_t r;
		bit        clipped;
		longint    ar;
		longint    ai;
		longint    br;
		longint    bi;
		clipped = 1'b0;
		ar = longint'(it.a_re);
		ai = longint'(it.a_im);
		br = longint'(it.b_re);
		bi = longint'(it.b_im);
		case (it.opcode)
			OP_ADD: begin
				r.res_re = clip_word(ar + br, clipped);
				r.res_im = clip_word(ai + bi, clipped);
			end
			OP_SUB: begin
				r.res_re = clip_word(ar - br, clipped);
				r.res_im = clip_word(ai - bi, clipped);
			end
			OP_MUL: begin
				r.res_re = clip_word(trunc_frac(ar * br - ai * bi), clipped);
				r.res_im = clip_word(trunc_frac(ar * bi + ai * br), clipped);
			end
			default: begin
				r.res_re = clip_word(floor_sqrt(ar * ar + ai * ai), clipped);
				r.res_im = '0;
			end
		endcase
		r.saturated = clipped;
		return r;
	endfunction

	function automatic stim_row_t row(input opcode_t op, input int ar, input int ai,
		input int br, input int bi, input bit typed, input int rr, input int ri,
		input bit sat);
		stim_row_t s;
		s.item.opcode   = op;
		s.item.a_re     = word_t'(ar);
		s.item.a_im     = word_t'(ai);
		s.item.b_re     = word_t'(br);
		s.item.b_im     = word_t'(bi);
		s.typed         = typed;
		s.want.res_re   = word_t'(rr);
		s.want.res_im   = word_t'(ri);
		s.want.saturated = sat;
		return s;
	endfunction

	function automatic word_t rand_operand();
		case ($urandom_range(0, 5))
			0, 1: return word_t'($urandom);
			2: return word_t'(int'($urandom_range(0, 1024)) - 512);
			3: begin
				case ($urandom_range(0, 3))
					0: return word_t'(32767);
					1: return word_t'(-32768);
					2: return word_t'(0);
					default: return word_t'(-1);
				endcase
			end
			4: begin
				if ($urandom_range(0, 1))
					return word_t'(32767 - int'($urandom_range(0, 300)));
				return word_t'(-32768 + int'($urandom_range(0, 300)));
			end
			default: return word_t'(int'($urandom_range(0, 16383)) - 8192);
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		$display("ERROR @%0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Present one transaction and hold it until the unit takes it.
	task automatic drive_item(input op_item_t it, input bit typed, input res_item_t want);
		op_valid <= 1'b1;
		op_data  <= it;
		do @(posedge clk); while (op_stall);
		pending_results.push_back(typed ? want : complex_op_result(it));
	endtask

	task automatic idle_for(input int n);
		op_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		op_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// End a burst now and then with a gap; long bursts leave stretches with no idling.
	task automatic maybe_gap();
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 30);
			idle_for($urandom_range(1, 12));
		end
	endtask

	// Receiver stall pattern: switch among modes every so often.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(8, 120);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 3) == 0);
			2: res_stall <= 1'($urandom_range(0, 1));
			default: res_stall <= ((stall_left % 16) < 6);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing expected",
					result_index));
			end else begin
				res_item_t exp_r;
				exp_r = pending_results.pop_front();
				if (res_data.res_re !== exp_r.res_re)
					report_mismatch($sformatf("result %0d res_re got %0d want %0d",
						result_index, res_data.res_re, exp_r.res_re));
				if (res_data.res_im !== exp_r.res_im)
					report_mismatch($sformatf("result %0d res_im got %0d want %0d",
						result_index, res_data.res_im, exp_r.res_im));
				if (res_data.saturated !== exp_r.saturated)
					report_mismatch($sformatf("result %0d saturated got %b want %b",
						result_index, res_data.saturated, exp_r.saturated));
			end
			result_index++;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		arst_n    <= 1'b0;
		op_valid  <= 1'b0;
		op_data   <= '0;

		// add: zero, both overflow directions, mixed signs
		dir_tab.push_back(row(OP_ADD, 0, 0, 0, 0, 1, 0, 0, 0));
		dir_tab.push_back(row(OP_ADD, 32767, 32767, 32767, 32767, 1, 32767, 32767, 1));
		dir_tab.push_back(row(OP_ADD, -32768, -32768, -32768, -32768, 1, -32768, -32768, 1));
		dir_tab.push_back(row(OP_ADD, 32767, -32768, -32768, 32767, 1, -1, -1, 0));
		dir_tab.push_back(row(OP_ADD, 32767, 0, 1, 0, 1, 32767, 0, 1));
		// subtract
		dir_tab.push_back(row(OP_SUB, -32768, 32767, 32767, -32768, 1, -32768, 32767, 1));
		dir_tab.push_back(row(OP_SUB, 0, 0, -32768, -32768, 1, 32767, 32767, 1));
		dir_tab.push_back(row(OP_SUB, 100, -100, 100, -100, 1, 0, 0, 0));
		// multiply: unit, i*i, truncation toward zero, overflow
		dir_tab.push_back(row(OP_MUL, 256, 0, 256, 0, 1, 256, 0, 0));
		dir_tab.push_back(row(OP_MUL, 0, 256, 0, 256, 1, -256, 0, 0));
		dir_tab.push_back(row(OP_MUL, -1, 0, 1, 0, 1, 0, 0, 0));
		dir_tab.push_back(row(OP_MUL, -257, 0, 1, 0, 1, -1, 0, 0));
		dir_tab.push_back(row(OP_MUL, -32768, -32768, -32768, -32768, 1, 0, 32767, 1));
		dir_tab.push_back(row(OP_MUL, -32768, 32767, 32767, -32768, 0, 0, 0, 0));
		dir_tab.push_back(row(OP_MUL, 32767, 32767, 32767, -32768, 0, 0, 0, 0));
		dir_tab.push_back(row(OP_MUL, -300, 77, 513, -1000, 0, 0, 0, 0));
		// modulus: B ignored, saturation above the top value
		dir_tab.push_back(row(OP_MOD, 768, 1024, -32768, 32767, 1, 1280, 0, 0));
		dir_tab.push_back(row(OP_MOD, 0, 0, 32767, -32768, 1, 0, 0, 0));
		dir_tab.push_back(row(OP_MOD, -32768, -32768, 0, 0, 1, 32767, 0, 1));
		dir_tab.push_back(row(OP_MOD, -32768, 0, 0, 0, 1, 32767, 0, 1));
		dir_tab.push_back(row(OP_MOD, 32767, 0, 0, 0, 1, 32767, 0, 0));
		dir_tab.push_back(row(OP_MOD, -3, -4, 0, 0, 1, 5, 0, 0));
		dir_tab.push_back(row(OP_MOD, 1, 1, 0, 0, 1, 1, 0, 0));
		dir_tab.push_back(row(OP_MOD, 23170, 23170, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(OP_MOD, 23170, -23171, 0, 0, 0, 0, 0, 0));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			drive_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
			maybe_gap();
		end
		wait_drained();
		@(posedge clk);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			rand_item.opcode = opcode_t'($urandom_range(0, 3));
			rand_item.a_re   = rand_operand();
			rand_item.a_im   = rand_operand();
			rand_item.b_re   = rand_operand();
			rand_item.b_im   = rand_operand();
			drive_item(rand_item, 1'b0, '0);
			if (n == RANDOM_ITEMS / 2) begin
				// hold off until the pipeline has emptied
				wait_drained();
				@(posedge clk);
			end else begin
				maybe_gap();
			end
		end

		wait_drained();
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

>>> files.f
sv/cau_pkg.sv
sv/cau_isqrt.sv
sv/complex_arith_unit.sv
sim/tb_top.sv
